// ===== rtl/mwm_pkg.sv =====
// Shared types, widths and constants of the mecanum wheel mixer.
// Used by every module of the mixer; depends on nothing else.
package mwm_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int SPEED_W     = 16;
    localparam int SUM_W       = 18;          // x +/- y +/- z, exact in Q.12
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = 34;          // signed sum * gain
    localparam int MAG_W       = 33;          // magnitude of that product
    localparam int MVC_W       = 15;
    localparam int LOUT_W      = 15;
    localparam int QUO_W       = 15;
    localparam int NUM_W       = MAG_W + QUO_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int PLAIN_W     = 17;
    localparam int CMD_W       = 16;
    localparam int VEL_SHIFT   = 20;
    localparam int PCT_SHIFT   = 10;
    localparam int LIMIT_W     = MVC_W + VEL_SHIFT;

    localparam logic [LOUT_W-1:0]  PCT_LIMIT_OUT = 15'd16384;   // 1.0 in Q1.14
    localparam logic [LIMIT_W-1:0] PCT_LIMIT     = 35'd16777216; // 1.0 in Q.24
    localparam logic [PLAIN_W-1:0] Q_CLAMP       = 17'd65536;

    // Wheel sign patterns: a set bit negates that term for the wheel.
    localparam logic [WHEEL_COUNT-1:0] STRAFE_NEG = 4'b0110;
    localparam logic [WHEEL_COUNT-1:0] TURN_NEG   = 4'b0011;

    // Register map, word index on paddr[3:2].
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_VGAIN  = 2'd1;
    localparam logic [1:0] REG_MAXV   = 2'd2;
    localparam logic [1:0] REG_INVTOP = 2'd3;

    typedef struct packed {
        logic stop;
        logic vel;
    } ctl_t;

    typedef struct packed {
        logic                   valid;
        ctl_t                   ctl;
        logic [WHEEL_COUNT-1:0] neg;
    } mix_ctl_t;

    typedef struct packed {
        logic                                valid;
        logic                                stop;
        logic                                vel;
        logic                                norm;
        logic [WHEEL_COUNT-1:0]              neg;
        logic [WHEEL_COUNT-1:0][PLAIN_W-1:0] plain;
    } side_t;

    // Applies the sign and saturates to a 16-bit command.
    function automatic logic [CMD_W-1:0] sat_cmd(input logic neg,
                                                 input logic [PLAIN_W-1:0] q);
        logic [PLAIN_W-1:0] neg_q;
        logic [CMD_W-1:0]   r;
        neg_q = PLAIN_W'(0) - q;
        if (!neg) begin
            r = (q > 17'd32767) ? 16'h7FFF : q[CMD_W-1:0];
        end else begin
            r = (q > 17'd32768) ? 16'h8000 : neg_q[CMD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/mwm_mix.sv =====
// Mixing front end: wheel sums, gain products and magnitudes in three stages.
// Depends on mwm_pkg.
module mwm_mix
    import mwm_pkg::*;
(
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  ctl_t                                in_ctl,
    input  logic signed [SPEED_W-1:0]           strafe,
    input  logic signed [SPEED_W-1:0]           forward,
    input  logic signed [SPEED_W-1:0]           turn,
    input  logic [GAIN_W-1:0]                   gain,
    output mix_ctl_t                            out_ctl,
    output logic [WHEEL_COUNT-1:0][MAG_W-1:0]   out_mag
);

    logic signed [SUM_W-1:0]  sum_next  [WHEEL_COUNT];
    logic signed [SUM_W-1:0]  sum_reg   [WHEEL_COUNT];
    logic signed [PROD_W-1:0] prod_next [WHEEL_COUNT];
    logic signed [PROD_W-1:0] prod_reg  [WHEEL_COUNT];
    logic [WHEEL_COUNT-1:0][MAG_W-1:0] mag_next;
    logic [WHEEL_COUNT-1:0][MAG_W-1:0] mag_reg;
    logic [WHEEL_COUNT-1:0]   neg_next;
    logic [WHEEL_COUNT-1:0]   neg_reg;
    logic [2:0]               valid_reg;
    ctl_t                     ctl1_reg, ctl2_reg, ctl3_reg;

    always_comb begin
        logic signed [SUM_W-1:0]  xs, ys, zs;
        logic signed [PROD_W-1:0] gain_ext;
        logic [PROD_W-1:0]        abs_v;
        xs = SUM_W'(strafe);
        ys = SUM_W'(forward);
        zs = SUM_W'(turn);
        gain_ext = $signed({{(PROD_W-GAIN_W){1'b0}}, gain});
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            sum_next[i] = (STRAFE_NEG[i] ? -xs : xs) + ys + (TURN_NEG[i] ? -zs : zs);
            prod_next[i] = PROD_W'(sum_reg[i]) * gain_ext;
            abs_v = prod_reg[i][PROD_W-1] ? (PROD_W'(0) - prod_reg[i]) : prod_reg[i];
            mag_next[i] = abs_v[MAG_W-1:0];
            neg_next[i] = prod_reg[i][PROD_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            for (int i = 0; i < WHEEL_COUNT; i++) begin
                sum_reg[i]  <= sum_next[i];
                prod_reg[i] <= prod_next[i];
            end
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    assign out_ctl.valid = valid_reg[2];
    assign out_ctl.ctl   = ctl3_reg;
    assign out_ctl.neg   = neg_reg;
    assign out_mag       = mag_reg;

endmodule

// ===== rtl/mwm_peak.sv =====
// Peak search, unscaled rounding and the divider numerators, in two stages.
// Depends on mwm_pkg.
module mwm_peak
    import mwm_pkg::*;
(
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  mix_ctl_t                            in_ctl,
    input  logic [WHEEL_COUNT-1:0][MAG_W-1:0]   in_mag,
    input  logic [MVC_W-1:0]                    max_counts,
    output side_t                               out_side,
    output logic [WHEEL_COUNT-1:0][NUM_W-1:0]   out_num,
    output logic [MAG_W-1:0]                    out_den
);

    logic [MAG_W-1:0]                    largest_next, largest4_reg, largest5_reg;
    logic [WHEEL_COUNT-1:0][MAG_W-1:0]   mag4_reg;
    logic [WHEEL_COUNT-1:0][PLAIN_W-1:0] plain_next, plain4_reg, plain5_reg;
    logic [WHEEL_COUNT-1:0][NUM_W-1:0]   num_next, num_reg;
    mix_ctl_t                            ctl4_reg, ctl5_reg;
    logic                                norm_next, norm_reg;
    logic                                valid4_reg, valid5_reg;

    always_comb begin
        logic [MAG_W-1:0] m01, m23;
        logic [MAG_W:0]   rnd_v, rnd_p, shifted;
        m01 = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
        m23 = (in_mag[2] > in_mag[3]) ? in_mag[2] : in_mag[3];
        largest_next = (m01 > m23) ? m01 : m23;
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            rnd_v = {1'b0, in_mag[i]} + ((MAG_W+1)'(1) << (VEL_SHIFT - 1));
            rnd_p = {1'b0, in_mag[i]} + ((MAG_W+1)'(1) << (PCT_SHIFT - 1));
            shifted = in_ctl.ctl.vel ? (rnd_v >> VEL_SHIFT) : (rnd_p >> PCT_SHIFT);
            plain_next[i] = (shifted > (MAG_W+1)'(Q_CLAMP)) ? Q_CLAMP
                                                            : shifted[PLAIN_W-1:0];
        end
    end

    always_comb begin
        logic [LIMIT_W-1:0] limit;
        logic [LOUT_W-1:0]  lout;
        limit = ctl4_reg.ctl.vel ? {max_counts, {VEL_SHIFT{1'b0}}} : PCT_LIMIT;
        lout  = ctl4_reg.ctl.vel ? max_counts : PCT_LIMIT_OUT;
        norm_next = LIMIT_W'(largest4_reg) > limit;
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            num_next[i] = NUM_W'(mag4_reg[i]) * NUM_W'(lout) + NUM_W'(largest4_reg >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end else if (en) begin
            valid4_reg <= in_ctl.valid;
            valid5_reg <= valid4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl4_reg     <= in_ctl;
            mag4_reg     <= in_mag;
            largest4_reg <= largest_next;
            plain4_reg   <= plain_next;
            ctl5_reg     <= ctl4_reg;
            largest5_reg <= largest4_reg;
            plain5_reg   <= plain4_reg;
            num_reg      <= num_next;
            norm_reg     <= norm_next;
        end
    end

    assign out_side.valid = valid5_reg;
    assign out_side.stop  = ctl5_reg.ctl.stop;
    assign out_side.vel   = ctl5_reg.ctl.vel;
    assign out_side.norm  = norm_reg;
    assign out_side.neg   = ctl5_reg.neg;
    assign out_side.plain = plain5_reg;
    assign out_num        = num_reg;
    assign out_den        = largest5_reg;

endmodule

// ===== rtl/mwm_div_lane.sv =====
// One lane of the pipelined restoring divider: one quotient bit per stage.
// Depends on mwm_pkg.
module mwm_div_lane
    import mwm_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [NUM_W-1:0]   num,
    input  logic [MAG_W-1:0]   den,
    output logic [QUO_W-1:0]   quo
);

    logic [MAG_W-1:0] rem_reg [DIV_STEPS];
    logic [QUO_W-1:0] low_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];
    logic [MAG_W-1:0] den_reg [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [MAG_W-1:0] rem_in, den_in;
        logic [QUO_W-1:0] low_in, quo_in;
        logic [MAG_W:0]   trial, diff;
        logic             fits;

        // The upper numerator bits start below the divisor whenever scaling
        // applies, so every stage yields exactly one quotient bit.
        if (g == 0) begin : g_first
            assign rem_in = num[NUM_W-1 -: MAG_W];
            assign low_in = num[QUO_W-1:0];
            assign quo_in = '0;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[g-1];
            assign low_in = low_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign den_in = den_reg[g-1];
        end

        assign trial = {rem_in, low_in[QUO_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign fits  = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                low_reg[g] <= {low_in[QUO_W-2:0], 1'b0};
                quo_reg[g] <= {quo_in[QUO_W-2:0], fits};
                den_reg[g] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

// ===== rtl/mecanum_wheel_mixer_top.sv =====
// Channel  | Dir | Payload
// s_       | in  | tdata: strafe, forward, turn speed; tuser: stop request
// m_       | out | tdata: wheel 0..3 commands; tuser: output mode, normalized flag
// APB      | in  | four configuration registers at byte addresses 0, 4, 8, 12
//
// One beat enters per cycle while the output is not stalled; a result passes
// through three mixing stages, two peak stages, fifteen divider stages (one
// quotient bit each) and the output register.
// A stalled output beat holds the whole pipeline, and s_tready drops with it.
// Reset is synchronous and clears the valid bits and the configuration registers.
// Top level of the mecanum wheel mixer; depends on mwm_pkg, mwm_mix, mwm_peak
// and mwm_div_lane.
module mecanum_wheel_mixer_top
    import mwm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // strafe_speed, forward_speed, turn_speed
    input  logic [0:0]           s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // wheel_zero_cmd .. wheel_three_cmd
    output logic [1:0]           m_tuser,   // output_mode, was_normalized
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic              vel_mode_reg;
    logic [GAIN_W-1:0] vgain_reg;
    logic [MVC_W-1:0]  maxv_reg;
    logic [GAIN_W-1:0] invtop_reg;
    logic              cfg_wr;
    logic              en;

    ctl_t                                in_ctl;
    mix_ctl_t                            mix_ctl;
    logic [WHEEL_COUNT-1:0][MAG_W-1:0]   mix_mag;
    side_t                               peak_side;
    logic [WHEEL_COUNT-1:0][NUM_W-1:0]   peak_num;
    logic [MAG_W-1:0]                    peak_den;
    logic [WHEEL_COUNT-1:0][QUO_W-1:0]   lane_quo;
    side_t                               side_reg [DIV_STEPS];
    side_t                               side_last;

    logic              out_valid_reg;
    logic [63:0]       tdata_next, tdata_reg;
    logic [1:0]        tuser_next, tuser_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_mode_reg <= 1'b0;
            vgain_reg    <= 16'd1024;
            maxv_reg     <= 15'd20000;
            invtop_reg   <= 16'd1024;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MODE:   vel_mode_reg <= pwdata[0];
                REG_VGAIN:  vgain_reg    <= pwdata[GAIN_W-1:0];
                REG_MAXV:   maxv_reg     <= pwdata[MVC_W-1:0];
                REG_INVTOP: invtop_reg   <= pwdata[GAIN_W-1:0];
                default:    vel_mode_reg <= vel_mode_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = {31'd0, vel_mode_reg};
            REG_VGAIN:  prdata = {16'd0, vgain_reg};
            REG_MAXV:   prdata = {17'd0, maxv_reg};
            REG_INVTOP: prdata = {16'd0, invtop_reg};
            default:    prdata = '0;
        endcase
    end

    // The whole pipeline moves together unless the output beat is held.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign in_ctl.stop = s_tuser[0];
    assign in_ctl.vel  = vel_mode_reg && !s_tuser[0];

    mwm_mix u_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_ctl   (in_ctl),
        .strafe   (s_tdata[15:0]),
        .forward  (s_tdata[31:16]),
        .turn     (s_tdata[47:32]),
        .gain     (vel_mode_reg ? vgain_reg : invtop_reg),
        .out_ctl  (mix_ctl),
        .out_mag  (mix_mag)
    );

    mwm_peak u_peak (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_ctl     (mix_ctl),
        .in_mag     (mix_mag),
        .max_counts (maxv_reg),
        .out_side   (peak_side),
        .out_num    (peak_num),
        .out_den    (peak_den)
    );

    for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_lane
        mwm_div_lane u_div (
            .aclk (aclk),
            .en   (en),
            .num  (peak_num[w]),
            .den  (peak_den),
            .quo  (lane_quo[w])
        );
    end

    // Sideband delay matching the divider depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < DIV_STEPS; g++) begin
                side_reg[g].valid <= 1'b0;
            end
        end else if (en) begin
            side_reg[0] <= peak_side;
            for (int g = 1; g < DIV_STEPS; g++) begin
                side_reg[g] <= side_reg[g-1];
            end
        end
    end

    assign side_last = side_reg[DIV_STEPS-1];

    always_comb begin
        logic [PLAIN_W-1:0] q;
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            q = side_last.norm ? PLAIN_W'(lane_quo[i]) : side_last.plain[i];
            tdata_next[CMD_W*i +: CMD_W] = side_last.stop ? '0 : sat_cmd(side_last.neg[i], q);
        end
        tuser_next = {side_last.norm && !side_last.stop, side_last.vel};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= side_last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

`ifndef SYNTHESIS
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the output beat is stalled");

    a_stop_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (side_last.valid && side_last.stop && en) |=>
            (m_tvalid && m_tdata == '0 && m_tuser == '0))
        else $error("stop request did not give zero commands");

    a_pct_norm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == 2'b10) |->
            ($signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384))
        else $error("normalized percent command beyond full scale");
`endif

endmodule

// ===== bench/mecanum_wheel_mixer_top_tb.sv =====
// Self-checking testbench for the mecanum wheel mixer: drives drive and stop beats,
// programs the registers over APB and checks every wheel beat against its own mixer.
// Depends on mwm_pkg and mecanum_wheel_mixer_top.
module mecanum_wheel_mixer_top_tb;
    import mwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic               stop;
        logic signed [15:0] strafe;
        logic signed [15:0] forward;
        logic signed [15:0] turn;
    } drive_cmd_t;

    typedef struct {
        logic signed [15:0] wheel [WHEEL_COUNT];
        logic               vel_mode;
        logic               normalized;
    } wheel_result_t;

    class mixer_scoreboard;
        wheel_result_t pending_wheels[$];
        bit            vel_mode;
        longint        vel_gain;
        longint        max_counts;
        longint        inv_top;
        int            mismatches;
        int            n_checked;
        int            n_stops;
        int            n_normalized;
        int            n_velocity;

        function new();
            vel_mode   = 1'b0;
            vel_gain   = 1024;
            max_counts = 20000;
            inv_top    = 1024;
        endfunction

        // Values are masked to the register widths, as the block does.
        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MODE:   vel_mode   = value[0];
                REG_VGAIN:  vel_gain   = value[15:0];
                REG_MAXV:   max_counts = value[14:0];
                REG_INVTOP: inv_top    = value[15:0];
                default: ;
            endcase
        endfunction

        function wheel_result_t predict_wheels(drive_cmd_t c);
            wheel_result_t r;
            longint        raw [WHEEL_COUNT];
            longint        mag [WHEEL_COUNT];
            longint        x, y, z, sum, gain, largest, limit, out_limit, q, v;
            int            shift;
            bit            norm;
            for (int i = 0; i < WHEEL_COUNT; i++) r.wheel[i] = '0;
            r.vel_mode   = 1'b0;
            r.normalized = 1'b0;
            if (c.stop) return r;

            x = c.strafe;
            y = c.forward;
            z = c.turn;
            gain = vel_mode ? vel_gain : inv_top;
            largest = 0;
            for (int i = 0; i < WHEEL_COUNT; i++) begin
                sum = y + (STRAFE_NEG[i] ? -x : x) + (TURN_NEG[i] ? -z : z);
                raw[i] = sum * gain;
                mag[i] = (raw[i] < 0) ? -raw[i] : raw[i];
                if (mag[i] > largest) largest = mag[i];
            end

            if (vel_mode) begin
                limit     = max_counts << VEL_SHIFT;
                out_limit = max_counts;
                shift     = VEL_SHIFT;
            end else begin
                limit     = longint'(1) << 24;
                out_limit = 16384;
                shift     = PCT_SHIFT;
            end
            norm = largest > limit;

            for (int i = 0; i < WHEEL_COUNT; i++) begin
                // Round half away from zero on the magnitude, then reapply the sign.
                if (norm)
                    q = (mag[i] * out_limit + largest / 2) / largest;
                else
                    q = (mag[i] + (longint'(1) << (shift - 1))) >> shift;
                if (q > 65536) q = 65536;
                v = (raw[i] < 0) ? -q : q;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                r.wheel[i] = v[15:0];
            end
            r.vel_mode   = vel_mode;
            r.normalized = norm;
            return r;
        endfunction

        function void note_drive(drive_cmd_t c);
            pending_wheels.push_back(predict_wheels(c));
            if (c.stop) n_stops++;
        endfunction

        function void check_wheels(wheel_result_t got);
            wheel_result_t exp;
            string         names [WHEEL_COUNT];
            names = '{"wheel_zero_cmd", "wheel_one_cmd", "wheel_two_cmd", "wheel_three_cmd"};
            if (pending_wheels.size() == 0) begin
                $error("wheel beat arrived with no command outstanding");
                mismatches++;
                return;
            end
            exp = pending_wheels.pop_front();
            n_checked++;
            if (exp.normalized) n_normalized++;
            if (exp.vel_mode) n_velocity++;
            for (int i = 0; i < WHEEL_COUNT; i++) begin
                if (got.wheel[i] !== exp.wheel[i]) begin
                    $error("%s: expected %0d, actual %0d", names[i], exp.wheel[i], got.wheel[i]);
                    mismatches++;
                end
            end
            if (got.vel_mode !== exp.vel_mode) begin
                $error("output_mode: expected %0d, actual %0d", exp.vel_mode, got.vel_mode);
                mismatches++;
            end
            if (got.normalized !== exp.normalized) begin
                $error("was_normalized: expected %0d, actual %0d",
                       exp.normalized, got.normalized);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_wheels.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [47:0]       s_tdata;    // strafe_speed, forward_speed, turn_speed
    logic [0:0]        s_tuser;    // req_type
    logic              m_tvalid;
    logic              m_tready;
    logic [63:0]       m_tdata;    // wheel_zero_cmd .. wheel_three_cmd
    logic [1:0]        m_tuser;    // output_mode, was_normalized
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    mixer_scoreboard sb = new();
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    int              settings_used;

    mecanum_wheel_mixer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Both monitors sample the values present just before the edge.
    always @(posedge aclk) begin
        drive_cmd_t    cmd;
        wheel_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cmd.stop    = s_tuser[0];
                cmd.strafe  = s_tdata[15:0];
                cmd.forward = s_tdata[31:16];
                cmd.turn    = s_tdata[47:32];
                sb.note_drive(cmd);
            end
            if (m_tvalid && m_tready) begin
                for (int i = 0; i < WHEEL_COUNT; i++) got.wheel[i] = m_tdata[16*i +: 16];
                got.vel_mode   = m_tuser[0];
                got.normalized = m_tuser[1];
                sb.check_wheels(got);
            end
        end
    end

    task automatic send_cmd(input logic stop, input logic [15:0] strafe,
                            input logic [15:0] forward, input logic [15:0] turn);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= stop;
        s_tdata  <= {turn, forward, strafe};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the input side until every outstanding wheel beat has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Leaves psel high so that writes can follow back to back.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(input logic [31:0] mode, input logic [31:0] gain,
                             input logic [31:0] max_cnt, input logic [31:0] inv);
        drain();
        apb_write(REG_MODE, mode);
        apb_write(REG_VGAIN, gain);
        apb_write(REG_MAXV, max_cnt);
        apb_write(REG_INVTOP, inv);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] rand_speed();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom_range(8191)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    // Half the time an extreme or the nominal reset value, otherwise any 32-bit word.
    function automatic logic [31:0] rand_reg(input logic [31:0] top, input logic [31:0] nominal);
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return top;
            2:       return nominal;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settings_used  = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: percent mode with a quarter of full scale per m/s.
        send_cmd(1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_cmd(1'b0, 16'h8000, 16'h8000, 16'h8000);
        send_cmd(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_cmd(1'b0, 16'h7FFF, 16'h0000, 16'h0000);
        send_cmd(1'b0, 16'h0000, 16'h0000, 16'h8000);
        send_cmd(1'b1, 16'h7FFF, 16'h8000, 16'h1234);

        // Percent mode at exactly 1.0 per m/s: one m/s sits on the limit.
        configure(32'd0, 32'd1024, 32'd20000, 32'd4096);
        send_cmd(1'b0, 16'd4096, 16'd0, 16'd0);
        send_cmd(1'b0, 16'd4097, 16'd0, 16'd0);
        send_cmd(1'b0, 16'd0, 16'd2048, 16'hF800);

        configure(32'd0, 32'd1024, 32'd20000, 32'hFFFF);
        send_cmd(1'b0, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_cmd(1'b0, 16'd1, 16'd0, 16'd0);

        configure(32'd0, 32'd1024, 32'd20000, 32'd0);
        send_cmd(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF);

        // Velocity mode, unit gain and a one-count limit: one m/s is on the limit.
        configure(32'd1, 32'd256, 32'd1, 32'd1024);
        send_cmd(1'b0, 16'd4096, 16'd0, 16'd0);
        send_cmd(1'b0, 16'd4097, 16'd0, 16'd0);
        send_cmd(1'b1, 16'h8000, 16'h8000, 16'h8000);

        // A zero count limit forces every wheel to zero once any wheel moves.
        configure(32'd1, 32'hFFFF, 32'd0, 32'd1024);
        send_cmd(1'b0, 16'd3, 16'hFFFF, 16'd0);
        send_cmd(1'b0, 16'd0, 16'd0, 16'd0);

        configure(32'd1, 32'hFFFF, 32'h7FFF, 32'hFFFF);
        send_cmd(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_cmd(1'b0, 16'h8000, 16'h7FFF, 16'h0001);

        configure(32'd1, 32'd0, 32'h7FFF, 32'd1024);
        send_cmd(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF);

        // Random part: three idle schedules, four register settings each.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 10; recv_stall_pct = 86; end
                1: begin send_idle_pct = 86; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                configure((blk % 2 == 0) ? 32'($urandom) : 32'hFFFF_FFFF,
                          rand_reg(32'hFFFF, 32'd1024), rand_reg(32'h7FFF, 32'd20000),
                          rand_reg(32'hFFFF, 32'd1024));
                for (int n = 0; n < 108; n++) begin
                    if (n == 54 && blk == 1) drain();
                    if ($urandom_range(99) < 8)
                        send_cmd(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
                    else
                        send_cmd(1'b0, rand_speed(), rand_speed(), rand_speed());
                end
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d wheel beats never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("Checked %0d wheel beats (%0d stop requests, %0d in velocity mode)",
                 sb.n_checked, sb.n_stops, sb.n_velocity);
        $display("across %0d register settings; %0d beats were scaled down to the limit.",
                 settings_used, sb.n_normalized);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
